@@ hw/rtl/abpf_pkg.sv @@
// Shared types, register codes and constants for the alpha blend pixel format block.
// No dependencies; every other file in hw/rtl imports this package.
package abpf_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int MAGIC_W    = 25;
   localparam int MAGIC_SHR  = 24;

   typedef enum logic [2:0] {
      REG_RED_SIZE    = 3'd0,
      REG_RED_SHIFT   = 3'd1,
      REG_GREEN_SIZE  = 3'd2,
      REG_GREEN_SHIFT = 3'd3,
      REG_BLUE_SIZE   = 3'd4,
      REG_BLUE_SHIFT  = 3'd5
   } abpf_reg_type;

   typedef struct packed {
      logic [31:0] source_argb;
      logic [31:0] dest_word;
   } abpf_req_type;

   typedef struct packed {
      logic [31:0] blended_word;
      logic        write_enable;
   } abpf_rsp_type;

   typedef struct packed {
      logic [3:0] red_size;
      logic [4:0] red_shift;
      logic [3:0] green_size;
      logic [4:0] green_shift;
      logic [3:0] blue_size;
      logic [4:0] blue_shift;
   } abpf_cfg_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } abpf_stage_en_type;

   // Reciprocals ceil(2^24 / (2^n - 1)) for channel sizes 1 to 8. With a 16-bit
   // dividend these give the exact truncated quotient after a shift by 24.
   localparam logic [MAGIC_W-1:0] MAGIC [0:7] = '{
      MAGIC_W'(((2**MAGIC_SHR) + 1   - 1) / 1),
      MAGIC_W'(((2**MAGIC_SHR) + 3   - 1) / 3),
      MAGIC_W'(((2**MAGIC_SHR) + 7   - 1) / 7),
      MAGIC_W'(((2**MAGIC_SHR) + 15  - 1) / 15),
      MAGIC_W'(((2**MAGIC_SHR) + 31  - 1) / 31),
      MAGIC_W'(((2**MAGIC_SHR) + 63  - 1) / 63),
      MAGIC_W'(((2**MAGIC_SHR) + 127 - 1) / 127),
      MAGIC_W'(((2**MAGIC_SHR) + 255 - 1) / 255)
   };

   // A size of zero behaves as one and anything above eight as eight.
   function automatic logic [3:0] eff_size(input logic [3:0] size);
      logic [3:0] res;
      begin
         if (size == 4'd0) begin
            res = 4'd1;
         end else if (size > 4'd8) begin
            res = 4'd8;
         end else begin
            res = size;
         end
         return res;
      end
   endfunction

endpackage

@@ hw/rtl/abpf_csr.sv @@
// Configuration register file behind the APB-style port.
// Depends on abpf_pkg for the register codes and the configuration struct.
module abpf_csr
   import abpf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output abpf_cfg_type          cfg
);

   abpf_cfg_type cfg_ff, cfg_in;
   abpf_reg_type reg_sel;
   logic         wr_en;

   assign reg_sel    = abpf_reg_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_RED_SIZE:    cfg_in.red_size    = csr_pwdata[3:0];
            REG_RED_SHIFT:   cfg_in.red_shift   = csr_pwdata[4:0];
            REG_GREEN_SIZE:  cfg_in.green_size  = csr_pwdata[3:0];
            REG_GREEN_SHIFT: cfg_in.green_shift = csr_pwdata[4:0];
            REG_BLUE_SIZE:   cfg_in.blue_size   = csr_pwdata[3:0];
            REG_BLUE_SHIFT:  cfg_in.blue_shift  = csr_pwdata[4:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.red_size    <= 4'd8;
         cfg_ff.red_shift   <= 5'd16;
         cfg_ff.green_size  <= 4'd8;
         cfg_ff.green_shift <= 5'd8;
         cfg_ff.blue_size   <= 4'd8;
         cfg_ff.blue_shift  <= 5'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_RED_SIZE:    csr_prdata = {28'd0, cfg_ff.red_size};
         REG_RED_SHIFT:   csr_prdata = {27'd0, cfg_ff.red_shift};
         REG_GREEN_SIZE:  csr_prdata = {28'd0, cfg_ff.green_size};
         REG_GREEN_SHIFT: csr_prdata = {27'd0, cfg_ff.green_shift};
         REG_BLUE_SIZE:   csr_prdata = {28'd0, cfg_ff.blue_size};
         REG_BLUE_SHIFT:  csr_prdata = {27'd0, cfg_ff.blue_shift};
         default:         csr_prdata = '0;
      endcase
   end

endmodule

@@ hw/rtl/abpf_ctrl.sv @@
// Valid bits and stall chain of the four-stage pipeline.
// Depends on abpf_pkg for the stage enable struct.
module abpf_ctrl
   import abpf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output abpf_stage_en_type en,
   output logic [3:0]        valid
);

   logic [3:0] valid_ff, valid_in;
   logic [3:0] ready;

   // A stage may load when it is empty or when the stage after it moves on.
   always_comb begin
      ready[3] = !valid_ff[3] || !rsp_stall;
      ready[2] = !valid_ff[2] || ready[3];
      ready[1] = !valid_ff[1] || ready[2];
      ready[0] = !valid_ff[0] || ready[1];
   end

   always_comb begin
      valid_in[0] = ready[0] ? req_valid   : valid_ff[0];
      valid_in[1] = ready[1] ? valid_ff[0] : valid_ff[1];
      valid_in[2] = ready[2] ? valid_ff[1] : valid_ff[2];
      valid_in[3] = ready[3] ? valid_ff[2] : valid_ff[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign en.s1     = ready[0];
   assign en.s2     = ready[1];
   assign en.s3     = ready[2];
   assign en.s4     = ready[3];
   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[3];
   assign valid     = valid_ff;

endmodule

@@ hw/rtl/abpf_chan.sv @@
// Datapath of one colour channel: unpack, expand, blend, normalise and repack.
// Depends on abpf_pkg for the reciprocal table, size clamp and enable struct.
module abpf_chan
   import abpf_pkg::*;
(
   input  logic              clock,
   input  abpf_stage_en_type en,
   input  logic [3:0]        size,
   input  logic [4:0]        shift,
   input  logic [31:0]       dest_word,
   input  logic [7:0]        src,
   input  logic [7:0]        alpha_s2,
   output logic [31:0]       placed
);

   logic [3:0]         eff;
   logic [7:0]         maxv;
   logic [2:0]         magic_idx;
   logic [31:0]        dest_sh;
   logic [15:0]        scaled;
   logic [40:0]        prod;
   logic [16:0]        mix_sum;
   logic [16:0]        norm_sum;
   logic [7:0]         mixed;
   logic [7:0]         trimmed;

   logic [7:0]  old_ff, old_in;
   logic [7:0]  src_s1_ff, src_s2_ff;
   logic [7:0]  exp_ff, exp_in;
   logic [15:0] mix_ff, mix_in;

   // The user must change the configuration only while the pipeline is empty; the block does not enforce it.
   assign eff       = eff_size(size);
   assign maxv      = 8'((9'd1 << eff) - 9'd1);
   assign magic_idx = 3'(eff - 4'd1);

   // Stage 1: pull the channel out of the destination word.
   assign dest_sh = dest_word >> shift;
   assign old_in  = dest_sh[7:0] & maxv;

   // Stage 2: expand to eight bits as old * 255 / maxv.
   assign scaled = ({8'd0, old_ff} << 8) - {8'd0, old_ff};
   assign prod   = {25'd0, scaled} * {16'd0, MAGIC[magic_idx]};
   assign exp_in = prod[MAGIC_SHR+7:MAGIC_SHR];

   // Stage 3: source-over mix; the sum never exceeds 255 * 255.
   assign mix_sum = 17'({8'd0, src_s2_ff} * {8'd0, alpha_s2})
                  + 17'({8'd0, exp_ff} * {8'd0, 8'd255 - alpha_s2});
   assign mix_in  = mix_sum[15:0];

   // Stage 4 logic: exact divide by 255 for any value up to 255 * 255, then repack.
   assign norm_sum = {1'b0, mix_ff} + 17'd1 + {9'd0, mix_ff[15:8]};
   assign mixed    = norm_sum[15:8];
   assign trimmed  = mixed >> (4'd8 - eff);
   assign placed   = {24'd0, trimmed} << shift;

   always_ff @(posedge clock) begin
      if (en.s1) begin
         old_ff    <= old_in;
         src_s1_ff <= src;
      end
      if (en.s2) begin
         exp_ff    <= exp_in;
         src_s2_ff <= src_s1_ff;
      end
      if (en.s3) begin
         mix_ff    <= mix_in;
      end
   end

endmodule

@@ hw/rtl/alpha_blend_pixel_format.sv @@
// Source-over blend of a straight-alpha ARGB8888 pixel into one framebuffer word whose red,
// green and blue fields are placed by the size and shift registers. The block is a
// four-stage pipeline of unpack, reciprocal multiply, mix multiply and repack stages: one
// word is taken every cycle while req_stall is low; rsp_stall holds the pipeline, and words
// still enter while earlier stages have bubbles. A zero source alpha returns the destination
// word with write_enable low. Change the registers only while no word is in flight.
module alpha_blend_pixel_format
   import abpf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  abpf_req_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output abpf_rsp_type          rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   abpf_cfg_type      cfg;
   abpf_stage_en_type en;
   logic [3:0]        valid;
   logic [31:0]       red_word, green_word, blue_word;

   logic [7:0]   alpha_s1_ff, alpha_s2_ff, alpha_s3_ff;
   logic [31:0]  dest_s1_ff, dest_s2_ff, dest_s3_ff;
   abpf_rsp_type rsp_ff, rsp_in;

   abpf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   abpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .en        (en),
      .valid     (valid)
   );

   abpf_chan u_red (
      .clock     (clock),
      .en        (en),
      .size      (cfg.red_size),
      .shift     (cfg.red_shift),
      .dest_word (req_data.dest_word),
      .src       (req_data.source_argb[23:16]),
      .alpha_s2  (alpha_s2_ff),
      .placed    (red_word)
   );

   abpf_chan u_green (
      .clock     (clock),
      .en        (en),
      .size      (cfg.green_size),
      .shift     (cfg.green_shift),
      .dest_word (req_data.dest_word),
      .src       (req_data.source_argb[15:8]),
      .alpha_s2  (alpha_s2_ff),
      .placed    (green_word)
   );

   abpf_chan u_blue (
      .clock     (clock),
      .en        (en),
      .size      (cfg.blue_size),
      .shift     (cfg.blue_shift),
      .dest_word (req_data.dest_word),
      .src       (req_data.source_argb[7:0]),
      .alpha_s2  (alpha_s2_ff),
      .placed    (blue_word)
   );

   // With zero alpha the destination word passes through untouched.
   always_comb begin
      if (alpha_s3_ff == 8'd0) begin
         rsp_in.blended_word = dest_s3_ff;
         rsp_in.write_enable = 1'b0;
      end else begin
         rsp_in.blended_word = red_word | green_word | blue_word;
         rsp_in.write_enable = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s1) begin
         alpha_s1_ff <= req_data.source_argb[31:24];
         dest_s1_ff  <= req_data.dest_word;
      end
      if (en.s2) begin
         alpha_s2_ff <= alpha_s1_ff;
         dest_s2_ff  <= dest_s1_ff;
      end
      if (en.s3) begin
         alpha_s3_ff <= alpha_s2_ff;
         dest_s3_ff  <= dest_s2_ff;
      end
      if (en.s4) begin
         rsp_ff      <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

   // The output stage can only move when every earlier stage can move too.
   a_stall_chain: assert property (@(posedge clock) disable iff (reset)
      en.s4 |-> (en.s3 && en.s2 && en.s1))
      else $error("stage enables out of order");

   // An accepted word must occupy the first stage on the next cycle.
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> valid[0])
      else $error("accepted word lost at pipeline entry");

   // A taken result with nothing behind it leaves the output empty.
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !valid[2]) |=> !rsp_valid)
      else $error("result repeated after it was taken");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for alpha_blend_pixel_format: blends pixels into framebuffer words
// under several channel layouts and checks every result word against a table value or its own predictor.
// Depends on abpf_pkg and the alpha_blend_pixel_format RTL only.
`timescale 1ns / 100ps

module tb_top;
   import abpf_pkg::*;

   localparam int RESET_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int RAND_PHASES  = 10;
   localparam int PHASE_WORDS  = 195;
   localparam int HOLD_AT      = 800;
   localparam int HOLD_LEN     = 300;
   localparam int N_FORMATS    = 7;
   localparam int N_CASES      = 23;

   typedef struct {
      int unsigned  fmt_idx;
      logic [31:0]  src;
      logic [31:0]  dest;
      bit           known;
      abpf_rsp_type want;
   } pixel_case_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   abpf_req_type          req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   abpf_rsp_type          rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   abpf_rsp_type pending_words[$];
   abpf_cfg_type fmt;
   int unsigned  mismatches = 0;
   int unsigned  words_in = 0;
   int unsigned  cycle_count = 0;
   int unsigned  hold_left = 0;
   bit           hold_done = 1'b0;
   bit           calm = 1'b0;

   // Layouts: reset xRGB8888, RGB565, out-of-range sizes, channels at the top of the word,
   // overlapping channels, every register at its maximum, every register at zero.
   abpf_cfg_type formats [N_FORMATS] = '{
      '{4'd8,  5'd16, 4'd8,  5'd8,  4'd8,  5'd0},
      '{4'd5,  5'd11, 4'd6,  5'd5,  4'd5,  5'd0},
      '{4'd0,  5'd0,  4'd15, 5'd8,  4'd9,  5'd16},
      '{4'd8,  5'd28, 4'd15, 5'd31, 4'd3,  5'd30},
      '{4'd8,  5'd4,  4'd4,  5'd6,  4'd8,  5'd4},
      '{4'd15, 5'd31, 4'd15, 5'd31, 4'd15, 5'd31},
      '{4'd0,  5'd0,  4'd0,  5'd0,  4'd0,  5'd0}
   };

   pixel_case_type cases [N_CASES] = '{
      '{0, 32'h00FFFFFF, 32'hDEADBEEF, 1'b1, '{32'hDEADBEEF, 1'b0}},
      '{0, 32'h00000000, 32'hFFFFFFFF, 1'b1, '{32'hFFFFFFFF, 1'b0}},
      '{0, 32'hFF123456, 32'hFFFFFFFF, 1'b1, '{32'h00123456, 1'b1}},
      '{0, 32'hFFFFFFFF, 32'h00000000, 1'b1, '{32'h00FFFFFF, 1'b1}},
      '{0, 32'hFF000000, 32'hFFFFFFFF, 1'b1, '{32'h00000000, 1'b1}},
      '{0, 32'h80FF0080, 32'h0000FF00, 1'b0, '{32'h0, 1'b0}},
      '{0, 32'h01FFFFFF, 32'h00000000, 1'b0, '{32'h0, 1'b0}},
      '{0, 32'hFE00FF00, 32'hFFFFFFFF, 1'b0, '{32'h0, 1'b0}},
      '{0, 32'h7F808080, 32'hAAAAAAAA, 1'b0, '{32'h0, 1'b0}},
      '{1, 32'hFFFFFFFF, 32'h00000000, 1'b1, '{32'h0000FFFF, 1'b1}},
      '{1, 32'h80F8FCF8, 32'h0000FFFF, 1'b0, '{32'h0, 1'b0}},
      '{1, 32'h40102030, 32'h12345678, 1'b0, '{32'h0, 1'b0}},
      '{2, 32'hFF80FF00, 32'h00000000, 1'b0, '{32'h0, 1'b0}},
      '{2, 32'h9C5A5A5A, 32'hFFFFFFFF, 1'b0, '{32'h0, 1'b0}},
      '{2, 32'h00ABCDEF, 32'h13579BDF, 1'b1, '{32'h13579BDF, 1'b0}},
      '{3, 32'hFFFFFFFF, 32'h00000000, 1'b0, '{32'h0, 1'b0}},
      '{3, 32'hC0123456, 32'hF0000000, 1'b0, '{32'h0, 1'b0}},
      '{4, 32'hFF0F00F0, 32'h00000000, 1'b0, '{32'h0, 1'b0}},
      '{4, 32'h33AA55CC, 32'hFFFF0000, 1'b0, '{32'h0, 1'b0}},
      '{5, 32'hFFFFFFFF, 32'h80000000, 1'b0, '{32'h0, 1'b0}},
      '{5, 32'h01000000, 32'hFFFFFFFF, 1'b0, '{32'h0, 1'b0}},
      '{6, 32'hFFFFFF00, 32'h00000000, 1'b1, '{32'h00000001, 1'b1}},
      '{6, 32'h80000000, 32'h00000001, 1'b0, '{32'h0, 1'b0}}
   };

   alpha_blend_pixel_format u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   // One channel: expand the old field to 8 bits, mix with the source, keep the top bits.
   function automatic logic [31:0] blend_field(input logic [31:0] dest,
                                               input logic [3:0] size_reg,
                                               input logic [4:0] shift,
                                               input logic [7:0] src, input logic [7:0] a);
      int unsigned width, maxv, old, expanded, mixed, sv, av;
      logic [63:0] placed;
      width    = (size_reg == 4'd0) ? 1 : (size_reg > 4'd8) ? 8 : size_reg;
      sv       = src;
      av       = a;
      maxv     = (32'd1 << width) - 1;
      old      = (dest >> shift) & maxv;
      expanded = (old * 255) / maxv;
      mixed    = (sv * av + expanded * (255 - av)) / 255;
      placed   = 64'(mixed >> (8 - width)) << shift;
      return placed[31:0];
   endfunction

   function automatic abpf_rsp_type blend_pixel(input abpf_req_type w);
      abpf_rsp_type res;
      logic [7:0] a;
      a = w.source_argb[31:24];
      if (a == 8'd0) begin
         res.blended_word = w.dest_word;
         res.write_enable = 1'b0;
      end else begin
         res.blended_word =
            blend_field(w.dest_word, fmt.red_size, fmt.red_shift, w.source_argb[23:16], a) |
            blend_field(w.dest_word, fmt.green_size, fmt.green_shift, w.source_argb[15:8], a) |
            blend_field(w.dest_word, fmt.blue_size, fmt.blue_shift, w.source_argb[7:0], a);
         res.write_enable = 1'b1;
      end
      return res;
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch on %s: expected %h, got %h", what, want, got);
      end
   endtask

   // Leaves psel and penable as they are, so that accesses can run back to back.
   task automatic csr_access(input logic write, input abpf_reg_type idx,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      rdata = csr_prdata;
   endtask

   task automatic set_reg(input abpf_reg_type idx, input logic [31:0] value);
      logic [31:0] rd;
      csr_access(1'b1, idx, value, rd);
      csr_access(1'b0, idx, '0, rd);
      if (rd !== value) begin
         flag_mismatch($sformatf("register %s readback", idx.name()), value, rd);
      end
   endtask

   task automatic program_format(input abpf_cfg_type c);
      set_reg(REG_RED_SIZE, 32'(c.red_size));
      set_reg(REG_RED_SHIFT, 32'(c.red_shift));
      set_reg(REG_GREEN_SIZE, 32'(c.green_size));
      set_reg(REG_GREEN_SHIFT, 32'(c.green_shift));
      set_reg(REG_BLUE_SIZE, 32'(c.blue_size));
      set_reg(REG_BLUE_SHIFT, 32'(c.blue_shift));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      fmt = c;
   endtask

   // Valid stays high on return; the caller lowers it only when it idles.
   task automatic send_word(input abpf_req_type w, input abpf_rsp_type want);
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      pending_words.push_back(want);
      words_in++;
   endtask

   task automatic maybe_idle();
      if (!calm && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_words.size() != 0) begin
         @(posedge clock);
      end
   endtask

   function automatic abpf_req_type rand_pixel();
      abpf_req_type w;
      logic [31:0] r;
      r = $urandom();
      case ($urandom_range(9))
         0: r[31:24] = 8'h00;
         1: r[31:24] = 8'hFF;
         2: r[31:24] = $urandom_range(1) ? 8'h01 : 8'hFE;
         default: ;
      endcase
      w.source_argb = r;
      case ($urandom_range(9))
         0: w.dest_word = 32'h0;
         1: w.dest_word = 32'hFFFFFFFF;
         default: w.dest_word = $urandom();
      endcase
      return w;
   endfunction

   function automatic abpf_cfg_type rand_format();
      abpf_cfg_type c;
      c.red_size    = 4'($urandom_range(15));
      c.red_shift   = 5'($urandom_range(31));
      c.green_size  = 4'($urandom_range(15));
      c.green_shift = 5'($urandom_range(31));
      c.blue_size   = 4'($urandom_range(15));
      c.blue_shift  = 5'($urandom_range(31));
      return c;
   endfunction

   // Receiving side: checks each accepted word and stalls at random, with one long hold.
   always @(posedge clock) begin
      abpf_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_words.size() == 0) begin
            flag_mismatch("unexpected word", 32'h0, rsp_data.blended_word);
         end else begin
            want = pending_words.pop_front();
            if (rsp_data.blended_word !== want.blended_word) begin
               flag_mismatch("blended_word", want.blended_word, rsp_data.blended_word);
            end
            if (rsp_data.write_enable !== want.write_enable) begin
               flag_mismatch("write_enable", 32'(want.write_enable),
                             32'(rsp_data.write_enable));
            end
         end
      end
      if (!hold_done && words_in >= HOLD_AT) begin
         hold_left = HOLD_LEN;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < 20);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      abpf_req_type w;
      int unsigned  cur_fmt;
      fmt     = formats[0];
      cur_fmt = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: the first rows run on the reset layout without any register write.
      foreach (cases[i]) begin
         if (cases[i].fmt_idx != cur_fmt) begin
            drain();
            cur_fmt = cases[i].fmt_idx;
            program_format(formats[cur_fmt]);
         end
         w.source_argb = cases[i].src;
         w.dest_word   = cases[i].dest;
         send_word(w, cases[i].known ? cases[i].want : blend_pixel(w));
      end

      for (int p = 0; p < RAND_PHASES; p++) begin
         drain();
         program_format(p < N_FORMATS ? formats[p] : rand_format());
         calm = (p == 3);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            // Halfway through one phase the sender waits until every word has come back.
            if (p == 5 && n == PHASE_WORDS / 2) begin
               drain();
            end
            maybe_idle();
            w = rand_pixel();
            send_word(w, blend_pixel(w));
         end
         calm = 1'b0;
      end

      drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && pending_words.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ alpha_blend_pixel_format.f @@
hw/rtl/abpf_pkg.sv
hw/rtl/abpf_csr.sv
hw/rtl/abpf_ctrl.sv
hw/rtl/abpf_chan.sv
hw/rtl/alpha_blend_pixel_format.sv
tb/tb_top.sv
